[sv/foft_pkg.sv]
`default_nettype none

package foft_pkg;

  // Fixed field widths of the transaction ports
  localparam int ActionW = 2;
  localparam int ItemW   = 10;
  localparam int AskedW  = 10;

  typedef enum logic [ActionW-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT,
    ST_HFROM,
    ST_HTO,
    ST_QRY
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clr;      // write zero at the sweep address, advance the sweep
    logic accept;   // capture the input transaction, issue first read
    logic cnt_wr;   // write the new count, read histogram at the old count
    logic hist_dec; // move one unit out of the old count, read the new count
    logic hist_inc; // move one unit into the new count
    logic q_load;   // load the query answer into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [ActionW-1:0] act;
    logic               item_ok;
    logic               cnt_ok;
    logic               clr_done;
    logic               out_free;
  } sts_t;

endpackage

`default_nettype wire

[sv/foft_ctrl.sv]
`default_nettype none

module foft_ctrl
  import foft_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (sts_i.act)
            ACT_INSERT, ACT_DELETE: state_d = sts_i.item_ok ? ST_CNT : ST_IDLE;
            ACT_QUERY:              state_d = ST_QRY;
            default:                state_d = ST_IDLE;
          endcase
        end
      end
      ST_CNT: begin
        state_d = sts_i.cnt_ok ? ST_HFROM : ST_IDLE;
      end
      ST_HFROM: state_d = ST_HTO;
      ST_HTO:   state_d = ST_IDLE;
      ST_QRY: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr = 1'b1;
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_CNT:   cmd_o.cnt_wr   = sts_i.cnt_ok;
      ST_HFROM: cmd_o.hist_dec = 1'b1;
      ST_HTO:   cmd_o.hist_inc = 1'b1;
      ST_QRY:   cmd_o.q_load   = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[sv/foft_dpath.sv]
`default_nettype none

module foft_dpath
  import foft_pkg::*;
#(
  parameter int VALUE_SLOTS = 1024,
  parameter int COUNT_MAX   = 1023
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ActionW-1:0] action_i,
  input  wire logic [ItemW-1:0]  item_value_i,
  input  wire logic [AskedW-1:0] asked_count_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   found_o,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o
);

  localparam int VW       = $clog2(VALUE_SLOTS);
  localparam int CW       = $clog2(COUNT_MAX + 1);
  localparam int NW       = $clog2(VALUE_SLOTS + 1);
  localparam int ClrDepth = (VALUE_SLOTS > COUNT_MAX + 1) ? VALUE_SLOTS : COUNT_MAX + 1;
  localparam int ClrW     = $clog2(ClrDepth);
  localparam logic [ClrW-1:0] ClrLast = ClrW'(ClrDepth - 1);

  logic [CW-1:0] cnt_mem  [VALUE_SLOTS];
  logic [NW-1:0] hist_mem [COUNT_MAX + 1];

  logic [ClrW-1:0] clr_q;
  logic [VW-1:0]   item_q;
  logic            is_ins_q;
  logic            qok_q;
  logic [CW-1:0]   from_q, to_q;
  logic [CW-1:0]   cnt_rdata_q;
  logic [NW-1:0]   hist_rdata_q;
  logic            out_valid_q, found_q;

  logic            item_ok, qok, cnt_ok;
  logic [CW-1:0]   cnt_new;
  logic            cnt_we;
  logic [VW-1:0]   cnt_waddr;
  logic [CW-1:0]   cnt_wdata;
  logic            hist_we, hist_re;
  logic [CW-1:0]   hist_waddr, hist_raddr;
  logic [NW-1:0]   hist_wdata;

  assign item_ok = 32'(item_value_i) < VALUE_SLOTS;
  assign qok     = (asked_count_i != '0) && (32'(asked_count_i) <= COUNT_MAX);

  assign cnt_ok  = is_ins_q ? (32'(cnt_rdata_q) < COUNT_MAX) : (cnt_rdata_q != '0);
  assign cnt_new = is_ins_q ? cnt_rdata_q + CW'(1) : cnt_rdata_q - CW'(1);

  // Count table port
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = item_q;
    cnt_wdata = cnt_new;
    priority if (cmd_i.clr) begin
      cnt_we    = 32'(clr_q) < VALUE_SLOTS;
      cnt_waddr = clr_q[VW-1:0];
      cnt_wdata = '0;
    end else if (cmd_i.cnt_wr) begin
      cnt_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cmd_i.accept) cnt_rdata_q <= cnt_mem[VW'(item_value_i)];
  end

  // Histogram port: read old count, then new count, each written back in the cycle after its read
  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = to_q;
    hist_wdata = hist_rdata_q + NW'(1);
    priority if (cmd_i.clr) begin
      hist_we    = 32'(clr_q) < COUNT_MAX + 1;
      hist_waddr = clr_q[CW-1:0];
      hist_wdata = '0;
    end else if (cmd_i.hist_dec) begin
      hist_we    = (from_q != '0) && (hist_rdata_q != '0);
      hist_waddr = from_q;
      hist_wdata = hist_rdata_q - NW'(1);
    end else if (cmd_i.hist_inc) begin
      hist_we = to_q != '0;
    end
  end

  always_comb begin
    hist_re = cmd_i.accept || cmd_i.cnt_wr || cmd_i.hist_dec;
    priority if (cmd_i.cnt_wr) begin
      hist_raddr = cnt_rdata_q;
    end else if (cmd_i.hist_dec) begin
      hist_raddr = to_q;
    end else begin
      hist_raddr = CW'(asked_count_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    if (hist_re) hist_rdata_q <= hist_mem[hist_raddr];
  end

  // Transaction capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q   <= VW'(item_value_i);
      is_ins_q <= action_i == ACT_INSERT;
      qok_q    <= qok;
    end
    if (cmd_i.cnt_wr) begin
      from_q <= cnt_rdata_q;
      to_q   <= cnt_new;
    end
    if (cmd_i.q_load) found_q <= qok_q && (hist_rdata_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr && clr_q != ClrLast) clr_q <= clr_q + ClrW'(1);
      if (cmd_i.q_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;

  always_comb begin
    sts_o.act      = action_i;
    sts_o.item_ok  = item_ok;
    sts_o.cnt_ok   = cnt_ok;
    sts_o.clr_done = clr_q == ClrLast;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

[sv/frequency_of_frequency_table.sv]
// Count-of-counts table. Keeps an occurrence count per value and a histogram
// of how many values hold each count; answers whether any value has a count.
// Input channel (in_valid_i/in_ready_o): action_i selects insert (0), delete
// (1) or query (2) of item_value_i / asked_count_i; action 3 is dropped.
// Output channel (out_valid_o/out_ready_i): one found_o transaction per query.
// Sequence: an insert or delete holds off the next transaction through its
// steps: accept, count read-modify-write, then one histogram read-modify-write
// for the old count and one for the new count, all through the single write
// port of each table. A query is accepted with its histogram read, then loads
// its answer into the output register once that register is free.
// Out-of-range values end an insert or delete at acceptance; a delete of an
// absent value or an insert at the saturated count ends after the count read.
// Reset: both tables are swept to zero, one entry per cycle, over
// max(VALUE_SLOTS, COUNT_MAX + 1) addresses; in_ready_o stays low meanwhile.
// Receiver stall: a pending answer holds in the output register while inserts
// and deletes keep flowing; a further query waits until the register frees.
`default_nettype none

module frequency_of_frequency_table
  import foft_pkg::*;
#(
  parameter int VALUE_SLOTS = 1024,
  parameter int COUNT_MAX   = 1023
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [ActionW-1:0] action_i,
  input  wire logic [ItemW-1:0]   item_value_i,
  input  wire logic [AskedW-1:0]  asked_count_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    found_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: clear sweep, idle, count update, histogram moves, query answer
  foft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Both tables, the transaction registers and the output register
  foft_dpath #(
    .VALUE_SLOTS (VALUE_SLOTS),
    .COUNT_MAX   (COUNT_MAX)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .action_i      (action_i),
    .item_value_i  (item_value_i),
    .asked_count_i (asked_count_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

`default_nettype wire
